FILE: rtl/sws_pkg.sv
`default_nettype none

package sws_pkg;

  // Default sizing of the sample ring.
  localparam int DEPTH_DEF        = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Configuration port geometry and register map.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  // Command codes of an input word.
  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_DROP  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic remove;
    logic commit;
    logic push;
    logic scan;
    logic div_load;
    logic div;
    logic publish;
  } sws_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_push;
    logic rm_done;
    logic scan_done;
    logic div_done;
  } sws_sts_t;

endpackage

`default_nettype wire

FILE: rtl/sws_ram.sv
`default_nettype none

module sws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/sws_ctrl.sv
`default_nettype none

module sws_ctrl
  import sws_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire sws_sts_t sts,
  output sws_ctl_t      ctl,
  output logic          busy
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REMOVE = 6'b000010,
    S_COMMIT = 6'b000100,
    S_PUSH   = 6'b001000,
    S_SCAN   = 6'b010000,
    S_DIV    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Sequence one command: removal, commit, push (push commands only), scan, divide.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.accept = 1'b1;
          state_nxt  = S_REMOVE;
        end
      end
      S_REMOVE: begin
        ctl.remove = 1'b1;
        if (sts.rm_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        ctl.commit = 1'b1;
        state_nxt  = sts.is_push ? S_PUSH : S_SCAN;
      end
      S_PUSH: begin
        ctl.push  = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_done) begin
          ctl.div_load = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        ctl.div = 1'b1;
        if (sts.div_done) begin
          ctl.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/sws_datapath.sv
`default_nettype none

module sws_datapath
  import sws_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int IDX_W       = $clog2(DEPTH),
  localparam int CNT_W       = $clog2(DEPTH + 1),
  localparam int SUM_W       = SAMPLE_WIDTH + $clog2(DEPTH)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire sws_ctl_t                       ctl,
  output sws_sts_t                            sts,
  input  wire logic        [1:0]              in_command,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic        [CNT_W-1:0]        in_drop_count,
  input  wire logic                           wlen_we,
  input  wire logic        [CNT_W-1:0]        wlen_wdata,
  output logic             [CNT_W-1:0]        wlen_r,
  output logic signed [SAMPLE_WIDTH-1:0]      out_removed_value,
  output logic                                out_removed_valid,
  output logic        [CNT_W-1:0]             out_count,
  output logic signed [SUM_W-1:0]             out_window_sum,
  output logic signed [SAMPLE_WIDTH-1:0]      out_window_mean,
  output logic signed [SAMPLE_WIDTH-1:0]      out_window_max,
  output logic signed [SAMPLE_WIDTH-1:0]      out_window_min,
  output logic                                out_empty_res,
  output logic                                out_strobe
);

  localparam int DK_W = $clog2(SUM_W + 1);
  localparam logic [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  cmd_t                    cmd_r;
  logic [SAMPLE_WIDTH-1:0] smp_r;
  logic [CNT_W-1:0]        rm_cnt_r;
  logic                    rvalid_r;
  logic [SAMPLE_WIDTH-1:0] removed_r;
  logic [CNT_W-1:0]        k_r;
  logic                    pend_r;
  logic [IDX_W-1:0]        oldest_r;
  logic [CNT_W-1:0]        held_r;
  logic [SUM_W-1:0]        sum_r;
  logic [SAMPLE_WIDTH-1:0] max_r;
  logic [SAMPLE_WIDTH-1:0] min_r;
  logic                    first_r;
  logic [SUM_W-1:0]        dvd_r;
  logic [CNT_W-1:0]        rem_r;
  logic [DK_W-1:0]         dk_r;
  logic                    neg_r;
  logic                    out_strobe_r;

  logic [CNT_W-1:0]        cap;
  logic [CNT_W-1:0]        bound;
  logic                    issue;
  logic [IDX_W-1:0]        raddr;
  logic [SAMPLE_WIDTH-1:0] rdata;
  logic [SUM_W-1:0]        rdata_ext;
  logic [SUM_W-1:0]        smp_ext;
  logic [CNT_W:0]          trial;
  logic                    qbit;
  logic [SAMPLE_WIDTH-1:0] quot;
  logic [SAMPLE_WIDTH-1:0] mean;

  // Ring slot at a given offset from the oldest sample; the sum stays
  // below twice the depth, so one subtract wraps it.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  // Effective capacity: zero acts as one, values above the depth as the depth.
  always_comb begin
    if (wlen_r == '0) begin
      cap = CNT_W'(1);
    end else if (wlen_r > CNT_W'(DEPTH)) begin
      cap = CNT_W'(DEPTH);
    end else begin
      cap = wlen_r;
    end
  end

  // Read sequencing shared by the removal pass and the max/min scan.
  assign bound     = ctl.remove ? rm_cnt_r : held_r;
  assign issue     = (ctl.remove || ctl.scan) && (k_r != bound);
  assign raddr     = slot_of(oldest_r, k_r);
  assign rdata_ext = {{(SUM_W-SAMPLE_WIDTH){rdata[SAMPLE_WIDTH-1]}}, rdata};
  assign smp_ext   = {{(SUM_W-SAMPLE_WIDTH){smp_r[SAMPLE_WIDTH-1]}}, smp_r};

  sws_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ctl.push),
    .waddr   (slot_of(oldest_r, held_r)),
    .wdata   (smp_r),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  // One restoring division step on the magnitude of the sum.
  assign trial = {rem_r, dvd_r[SUM_W-1]};
  assign qbit  = (trial >= {1'b0, held_r});
  assign quot  = dvd_r[SAMPLE_WIDTH-1:0];
  assign mean  = (held_r == '0) ? '0 : (neg_r ? (~quot + 1'b1) : quot);

  assign sts.is_push   = (cmd_r == CMD_PUSH);
  assign sts.rm_done   = (k_r == rm_cnt_r) && !pend_r;
  assign sts.scan_done = (k_r == held_r) && !pend_r;
  assign sts.div_done  = (dk_r == '0);

  // Window state: pointer, count, sum and window length.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      held_r   <= '0;
      sum_r    <= '0;
      wlen_r   <= CNT_W'(DEPTH);
      pend_r   <= 1'b0;
    end else begin
      pend_r <= issue;
      if (wlen_we) begin
        wlen_r   <= wlen_wdata;
        oldest_r <= '0;
        held_r   <= '0;
        sum_r    <= '0;
      end else if (ctl.accept && (in_command == CMD_CLEAR)) begin
        oldest_r <= '0;
        held_r   <= '0;
        sum_r    <= '0;
      end else if (ctl.remove && pend_r) begin
        sum_r <= sum_r - rdata_ext;
      end else if (ctl.commit) begin
        oldest_r <= slot_of(oldest_r, rm_cnt_r);
        held_r   <= held_r - rm_cnt_r;
      end else if (ctl.push) begin
        held_r <= held_r + 1'b1;
        sum_r  <= sum_r + smp_ext;
      end
    end
  end

  // Command capture and removal bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r    <= CMD_CLEAR;
      rm_cnt_r <= '0;
      rvalid_r <= 1'b0;
      k_r      <= '0;
    end else if (ctl.accept) begin
      cmd_r <= cmd_t'(in_command);
      k_r   <= '0;
      case (cmd_t'(in_command))
        CMD_PUSH: begin
          rvalid_r <= (held_r >= cap);
          rm_cnt_r <= (held_r >= cap) ? CNT_W'(1) : '0;
        end
        CMD_POP: begin
          rvalid_r <= (held_r != '0);
          rm_cnt_r <= (held_r != '0) ? CNT_W'(1) : '0;
        end
        CMD_DROP: begin
          rvalid_r <= 1'b0;
          rm_cnt_r <= (in_drop_count > held_r) ? held_r : in_drop_count;
        end
        default: begin
          rvalid_r <= 1'b0;
          rm_cnt_r <= '0;
        end
      endcase
    end else if (ctl.commit) begin
      k_r <= '0;
    end else if (issue) begin
      k_r <= k_r + 1'b1;
    end
  end

  // Removed sample, captured from the ring on a pop or an eviction.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      smp_r     <= in_sample;
      removed_r <= '0;
    end else if (ctl.remove && pend_r && rvalid_r) begin
      removed_r <= rdata;
    end
  end

  // Maximum and minimum over the held samples.
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      max_r   <= MOST_NEG;
      min_r   <= MOST_NEG;
      first_r <= 1'b1;
    end else if (ctl.scan && pend_r) begin
      first_r <= 1'b0;
      if (first_r || ($signed(rdata) > $signed(max_r))) begin
        max_r <= rdata;
      end
      if (first_r || ($signed(rdata) < $signed(min_r))) begin
        min_r <= rdata;
      end
    end
  end

  // Serial divider for the mean, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dk_r <= '0;
    end else if (ctl.div_load) begin
      dvd_r <= sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
      neg_r <= sum_r[SUM_W-1];
      rem_r <= '0;
      dk_r  <= DK_W'(SUM_W);
    end else if (ctl.div && (dk_r != '0)) begin
      rem_r <= qbit ? CNT_W'(trial - {1'b0, held_r}) : trial[CNT_W-1:0];
      dvd_r <= {dvd_r[SUM_W-2:0], qbit};
      dk_r  <= dk_r - 1'b1;
    end
  end

  // Result register, loaded on publish and held until the next one.
  always_ff @(posedge clk) begin
    if (ctl.publish) begin
      out_removed_value <= removed_r;
      out_removed_valid <= rvalid_r;
      out_count         <= held_r;
      out_window_sum    <= sum_r;
      out_window_mean   <= mean;
      out_window_max    <= max_r;
      out_window_min    <= min_r;
      out_empty_res     <= (held_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctl.publish;
    end
  end

  assign out_strobe = out_strobe_r;

endmodule

`default_nettype wire

FILE: rtl/sliding_window_ring_statistics.sv
// Sliding window statistics over a ring of signed fixed-point samples.
//
// Input channel: a command word (in_command, in_sample, in_drop_count) is
// taken at a rising edge with start high and busy low. Commands push a
// sample (evicting the oldest when the window is full), pop the oldest,
// drop several of the oldest, or clear the window.
// Result channel: one result word per command, shown for exactly one cycle
// with out_strobe high. The receiver cannot stall; out_strobe is the only
// qualifier and the word must be taken in that cycle.
// Sequence: a command runs a removal pass, a commit, a push (pushes only),
// a max/min scan and a divide of the SUM_W-bit sum (SUM_W is 22 at the
// default sizing). The removal pass and the max/min scan each read one
// ring entry per cycle through the single RAM read port, and the mean
// comes from a divider that forms one quotient bit per cycle. busy drops
// in the cycle out_strobe is shown, so the next command may start right there.
// Configuration: window_length at byte address 0 of the APB port; a write
// empties the window. The user must write only while busy is low; the
// block itself does not enforce it.
// Reset: the window is empty and window_length equals the depth. The ring
// needs no clearing, since only written entries are ever read.
`default_nettype none

module sliding_window_ring_statistics
  import sws_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int CNT_W       = $clog2(DEPTH + 1),
  localparam int SUM_W       = SAMPLE_WIDTH + $clog2(DEPTH)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic        [1:0]              in_command,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic        [CNT_W-1:0]        in_drop_count,
  output logic signed [SAMPLE_WIDTH-1:0]      out_removed_value,
  output logic                                out_removed_valid,
  output logic        [CNT_W-1:0]             out_count,
  output logic signed [SUM_W-1:0]             out_window_sum,
  output logic signed [SAMPLE_WIDTH-1:0]      out_window_mean,
  output logic signed [SAMPLE_WIDTH-1:0]      out_window_max,
  output logic signed [SAMPLE_WIDTH-1:0]      out_window_min,
  output logic                                out_empty_res,
  output logic                                out_strobe,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [CFG_ADDR_W-1:0]          paddr,
  input  wire logic [CFG_DATA_W-1:0]          pwdata,
  output logic      [CFG_DATA_W-1:0]          prdata,
  output logic                                pready
);

  sws_ctl_t         ctl;
  sws_sts_t         sts;
  logic             wlen_we;
  logic [CNT_W-1:0] wlen;

  // Register decode: one register, selected by the word address bit.
  assign pready  = 1'b1;
  assign wlen_we = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH);
  assign prdata  = (paddr[2] == REG_WINDOW_LENGTH) ?
                   {{(CFG_DATA_W-CNT_W){1'b0}}, wlen} : '0;

  sws_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  sws_datapath #(
    .DEPTH        (DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .in_command        (in_command),
    .in_sample         (in_sample),
    .in_drop_count     (in_drop_count),
    .wlen_we           (wlen_we),
    .wlen_wdata        (pwdata[CNT_W-1:0]),
    .wlen_r            (wlen),
    .out_removed_value (out_removed_value),
    .out_removed_valid (out_removed_valid),
    .out_count         (out_count),
    .out_window_sum    (out_window_sum),
    .out_window_mean   (out_window_mean),
    .out_window_max    (out_window_max),
    .out_window_min    (out_window_min),
    .out_empty_res     (out_empty_res),
    .out_strobe        (out_strobe)
  );

endmodule

`default_nettype wire

FILE: rtl/sws_checker.sv
`default_nettype none

module sws_checker
  import sws_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int CNT_W       = $clog2(DEPTH + 1),
  localparam int SUM_W       = SAMPLE_WIDTH + $clog2(DEPTH)
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           out_strobe,
  input wire logic                           out_removed_valid,
  input wire logic signed [SAMPLE_WIDTH-1:0] out_removed_value,
  input wire logic        [CNT_W-1:0]        out_count,
  input wire logic signed [SUM_W-1:0]        out_window_sum,
  input wire logic signed [SAMPLE_WIDTH-1:0] out_window_mean,
  input wire logic signed [SAMPLE_WIDTH-1:0] out_window_max,
  input wire logic signed [SAMPLE_WIDTH-1:0] out_window_min,
  input wire logic                           out_empty_res
);

  localparam logic signed [SAMPLE_WIDTH-1:0] MOST_NEG =
    {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // A taken command raises busy.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // The result appears as the block returns to idle, one word per command.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (!busy && !$past(out_strobe)))
    else $error("result strobe while busy or repeated");

  // An empty window reports zero sum and mean and the most negative extremes.
  a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_empty_res) |->
      (out_count == '0 && out_window_sum == '0 && out_window_mean == '0 &&
       out_window_max == MOST_NEG && out_window_min == MOST_NEG))
    else $error("empty window result inconsistent");

  // A held window has ordered extremes and a mean between them.
  a_held_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_empty_res) |->
      (out_count != '0 && out_window_min <= out_window_max &&
       out_window_mean <= out_window_max && out_window_mean >= out_window_min))
    else $error("window extremes or mean out of order");

  // Without a removed sample the removed value reads as zero.
  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_removed_valid) |-> (out_removed_value == '0))
    else $error("removed value set without a removed sample");

endmodule

bind sliding_window_ring_statistics sws_checker #(
  .DEPTH        (DEPTH),
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_sws_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_removed_valid (out_removed_valid),
  .out_removed_value (out_removed_value),
  .out_count         (out_count),
  .out_window_sum    (out_window_sum),
  .out_window_mean   (out_window_mean),
  .out_window_max    (out_window_max),
  .out_window_min    (out_window_min),
  .out_empty_res     (out_empty_res)
);

`default_nettype wire

FILE: bench/sws_stats_checker.sv
`default_nettype none

module sws_stats_checker
  import sws_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire logic [1:0]            in_command,
  input  wire logic signed [15:0]    in_sample,
  input  wire logic [6:0]            in_drop_count,
  input  wire logic signed [15:0]    out_removed_value,
  input  wire logic                  out_removed_valid,
  input  wire logic [6:0]            out_count,
  input  wire logic signed [21:0]    out_window_sum,
  input  wire logic signed [15:0]    out_window_mean,
  input  wire logic signed [15:0]    out_window_max,
  input  wire logic signed [15:0]    out_window_min,
  input  wire logic                  out_empty_res,
  input  wire logic                  out_strobe,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  input  wire logic                  pready,
  output int                         failure_count,
  output int                         pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_SIZE = DEPTH_DEF;
  localparam logic signed [15:0] MOST_NEG = 16'sh8000;

  // One result word as the block should report it.
  typedef struct {
    logic signed [15:0] removed;
    logic               removed_ok;
    logic [6:0]         held;
    logic signed [21:0] total;
    logic signed [15:0] mean;
    logic signed [15:0] maxv;
    logic signed [15:0] minv;
    logic               empty;
  } stats_word_t;

  // Shadow copy of the window.
  logic signed [15:0] ring_samples [RING_SIZE];
  int unsigned        ring_head;
  int unsigned        ring_held;
  longint             ring_total;
  logic [6:0]         window_cfg;

  stats_word_t expected_stats [$];
  int          mismatches = 0;

  assign failure_count = mismatches;

  function automatic void clear_window();
    ring_head = 0;
    ring_held = 0;
    ring_total = 0;
  endfunction

  // Window length as the block applies it: zero acts as one, above depth as depth.
  function automatic int unsigned capacity();
    if (window_cfg == 0) return 1;
    if (window_cfg > RING_SIZE) return RING_SIZE;
    return window_cfg;
  endfunction

  function automatic logic signed [15:0] take_oldest();
    logic signed [15:0] v;
    v = ring_samples[ring_head];
    ring_head = (ring_head + 1) % RING_SIZE;
    ring_held--;
    ring_total -= v;
    return v;
  endfunction

  // Apply one command to the shadow window and form the statistics word.
  function automatic stats_word_t predict_command(cmd_t cmd, logic signed [15:0] smp,
                                                  logic [6:0] n);
    stats_word_t w;
    int unsigned drop_n;
    logic signed [15:0] e;
    longint q;
    w.removed = '0;
    w.removed_ok = 1'b0;
    case (cmd)
      CMD_PUSH: begin
        if (ring_held >= capacity()) begin
          w.removed = take_oldest();
          w.removed_ok = 1'b1;
        end
        ring_samples[(ring_head + ring_held) % RING_SIZE] = smp;
        ring_held++;
        ring_total += smp;
      end
      CMD_POP: begin
        if (ring_held > 0) begin
          w.removed = take_oldest();
          w.removed_ok = 1'b1;
        end
      end
      CMD_DROP: begin
        drop_n = (n > ring_held) ? ring_held : n;
        repeat (drop_n) void'(take_oldest());
      end
      default: clear_window();
    endcase

    w.maxv = MOST_NEG;
    w.minv = MOST_NEG;
    w.mean = '0;
    if (ring_held > 0) begin
      w.maxv = ring_samples[ring_head];
      w.minv = w.maxv;
      for (int unsigned i = 1; i < ring_held; i++) begin
        e = ring_samples[(ring_head + i) % RING_SIZE];
        if (e > w.maxv) w.maxv = e;
        if (e < w.minv) w.minv = e;
      end
      // Signed division truncates toward zero.
      q = ring_total / longint'(ring_held);
      w.mean = q[15:0];
    end
    w.held = ring_held[6:0];
    w.total = ring_total[21:0];
    w.empty = (ring_held == 0);
    return w;
  endfunction

  task automatic compare_field(input string fname, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endtask

  // Watch both channels and the register port at every edge.
  always @(posedge clk) begin : watch
    stats_word_t want;
    if (!rst_n) begin
      clear_window();
      window_cfg = 7'd64;
      expected_stats.delete();
    end else begin
      if (out_strobe) begin
        if (expected_stats.size() == 0) begin
          $error("result word with no command outstanding");
          mismatches++;
        end else begin
          want = expected_stats.pop_front();
          compare_field("removed_value", want.removed, out_removed_value);
          compare_field("removed_valid", want.removed_ok, out_removed_valid);
          compare_field("count", want.held, out_count);
          compare_field("window_sum", want.total, out_window_sum);
          compare_field("window_mean", want.mean, out_window_mean);
          compare_field("window_max", want.maxv, out_window_max);
          compare_field("window_min", want.minv, out_window_min);
          compare_field("empty_res", want.empty, out_empty_res);
        end
      end
      // A window length write also empties the window.
      if (psel && penable && pwrite && pready &&
          paddr[CFG_ADDR_W-1:2] == REG_WINDOW_LENGTH) begin
        window_cfg = pwdata[6:0];
        clear_window();
      end
      if (start && !busy)
        expected_stats.push_back(predict_command(cmd_t'(in_command), in_sample,
                                                 in_drop_count));
    end
    pending_words <= expected_stats.size();
  end

endmodule

`default_nettype wire

FILE: bench/tb_sliding_window_ring_statistics.sv
`default_nettype none

module tb_sliding_window_ring_statistics
  import sws_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [1:0]            in_command;
  logic signed [15:0]    in_sample;
  logic [6:0]            in_drop_count;
  logic signed [15:0]    out_removed_value;
  logic                  out_removed_valid;
  logic [6:0]            out_count;
  logic signed [21:0]    out_window_sum;
  logic signed [15:0]    out_window_mean;
  logic signed [15:0]    out_window_max;
  logic signed [15:0]    out_window_min;
  logic                  out_empty_res;
  logic                  out_strobe;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int failure_count;
  int pending_words;
  int idle_pct;
  int idle_cycles;
  int sender_idle [3] = '{34, 84, 0};

  sliding_window_ring_statistics i_dut (
    .clk, .rst_n, .start, .busy,
    .in_command, .in_sample, .in_drop_count,
    .out_removed_value, .out_removed_valid, .out_count, .out_window_sum,
    .out_window_mean, .out_window_max, .out_window_min, .out_empty_res, .out_strobe,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sws_stats_checker i_checker (
    .clk, .rst_n, .start, .busy,
    .in_command, .in_sample, .in_drop_count,
    .out_removed_value, .out_removed_valid, .out_count, .out_window_sum,
    .out_window_mean, .out_window_max, .out_window_min, .out_empty_res, .out_strobe,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .failure_count, .pending_words
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: cycles in which neither a command nor a result word is taken.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Present one command word and hold it until the block takes it.
  task automatic send_word(input cmd_t cmd, input logic signed [15:0] smp,
                           input logic [6:0] cnt);
    // Now and then a long gap, sometimes placed after the block goes idle.
    if (idle_pct != 0 && $urandom_range(0, 9) == 0) begin
      start <= 1'b0;
      @(posedge clk);
      if ($urandom_range(0, 1) == 1)
        while (busy) @(posedge clk);
      repeat ($urandom_range(1, 110)) @(posedge clk);
    end
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_command    <= cmd;
    in_sample     <= smp;
    in_drop_count <= cnt;
    do @(posedge clk); while (busy);
  endtask

  // Write the window length once every result word is in; random upper bits.
  task automatic write_window(input logic [6:0] len);
    start <= 1'b0;
    @(posedge clk);
    while (pending_words != 0 || busy) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_WINDOW_LENGTH, 2'b00};
    pwdata  <= {25'($urandom()), len};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random command; fill mode mostly pushes so the window runs full and evicts.
  task automatic send_random(input bit fill);
    int unsigned pick;
    cmd_t cmd;
    logic signed [15:0] smp;
    logic [6:0] cnt;
    pick = $urandom_range(0, 99);
    if (fill)
      cmd = (pick < 92) ? CMD_PUSH : CMD_POP;
    else if (pick < 62)
      cmd = CMD_PUSH;
    else if (pick < 80)
      cmd = CMD_POP;
    else if (pick < 96)
      cmd = CMD_DROP;
    else
      cmd = CMD_CLEAR;
    case ($urandom_range(0, 19))
      0:       smp = 16'sh8000;
      1:       smp = 16'sh7fff;
      2:       smp = '0;
      3:       smp = -16'sd1;
      default: smp = 16'($urandom());
    endcase
    pick = $urandom_range(0, 9);
    if (pick < 7)
      cnt = 7'($urandom_range(0, 6));
    else if (pick < 9)
      cnt = 7'($urandom_range(0, 64));
    else
      cnt = 7'($urandom_range(0, 127));
    send_word(cmd, smp, cnt);
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_command    = CMD_CLEAR;
    in_sample     = '0;
    in_drop_count = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    idle_pct      = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-window pop and drops, sample extremes, saturating drop.
    send_word(CMD_POP, 16'sd5, 7'd0);
    send_word(CMD_DROP, '0, 7'd0);
    send_word(CMD_DROP, '0, 7'd127);
    send_word(CMD_PUSH, 16'sh7fff, 7'd0);
    send_word(CMD_PUSH, 16'sh8000, 7'd0);
    send_word(CMD_PUSH, 16'sd0, 7'd0);
    send_word(CMD_PUSH, -16'sd1, 7'd0);
    send_word(CMD_PUSH, 16'sd1, 7'd0);
    send_word(CMD_DROP, '0, 7'd0);
    send_word(CMD_POP, '0, 7'd0);
    send_word(CMD_DROP, '0, 7'd2);
    send_word(CMD_DROP, '0, 7'd64);
    send_word(CMD_PUSH, 16'sh0100, 7'd0);
    send_word(CMD_CLEAR, 16'sh7fff, 7'd127);
    send_word(CMD_PUSH, 16'sh8000, 7'd0);

    // Window of two: pushes past the length evict the oldest.
    write_window(7'd2);
    send_word(CMD_PUSH, 16'sd100, 7'd0);
    send_word(CMD_PUSH, -16'sd200, 7'd0);
    send_word(CMD_PUSH, 16'sd300, 7'd0);
    send_word(CMD_PUSH, 16'sh7fff, 7'd0);
    send_word(CMD_POP, '0, 7'd0);
    send_word(CMD_POP, '0, 7'd0);
    send_word(CMD_POP, '0, 7'd0);

    // A zero length behaves as a window of one.
    write_window(7'd0);
    send_word(CMD_PUSH, -16'sd5, 7'd0);
    send_word(CMD_PUSH, 16'sd7, 7'd0);
    send_word(CMD_DROP, '0, 7'd1);

    // Random part in three idling phases, each over several window lengths.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = sender_idle[ph];
      write_window((ph == 0) ? 7'd127 : 7'd64);
      repeat (90) send_random(1'b1);
      write_window((ph == 1) ? 7'd0 : 7'd1);
      repeat (30) send_random(1'b0);
      write_window(7'($urandom_range(2, 63)));
      repeat (45) send_random(1'b0);
      write_window((ph == 2) ? 7'd127 : 7'($urandom_range(33, 64)));
      repeat (50) send_random(1'b0);
    end

    // Drain, then allow time for any stray result word.
    start <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (failure_count == 0 && pending_words == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
